// ===== src/csrs_pkg.sv =====
// Shared types and constants for the channel-sum running statistics block.
// No dependencies; imported by every module of the block.
package csrs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_W       = 11;
    localparam int SUM_W       = 26;
    localparam int MEAN_W      = SUM_W + FRAC_BITS;
    localparam int DEV_W       = MEAN_W + 1;
    localparam int MAG_W       = MEAN_W;
    localparam int HALF_W      = (MAG_W + 1) / 2;
    localparam int PROD_W      = 4 * HALF_W;
    localparam int M2_W        = 63;
    localparam int CNT_W       = 32;
    localparam int STEP_W      = $clog2(MAG_W);

    localparam int OFS_SUM   = 0;
    localparam int OFS_MIN   = OFS_SUM + SUM_W;
    localparam int OFS_MAX   = OFS_MIN + SUM_W;
    localparam int OFS_MEAN  = OFS_MAX + SUM_W;
    localparam int OFS_DEV   = OFS_MEAN + MEAN_W;
    localparam int OFS_CNT   = OFS_DEV + M2_W;
    localparam int OUT_BITS  = OFS_CNT + CNT_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [M2_W-1:0]  M2_MAX  = {M2_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    new_run;
    } csrs_entry_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MEAN = 6'b000100,
        S_MUL  = 6'b001000,
        S_ACC  = 6'b010000,
        S_EMIT = 6'b100000
    } back_state_t;

endpackage

// ===== src/csrs_front.sv =====
// Front end: channel count register, channel summing and run restart tracking.
// Depends on csrs_pkg; pushes completed time samples into csrs_queue.
module csrs_front
    import csrs_pkg::*;
#(
    parameter int CHANNELS_MAX = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,
    input  logic [0:0]             s_tuser,
    input  logic                   queue_full,
    output logic                   push,
    output csrs_entry_t            push_entry
);

    localparam int IDX_W = (CHANNELS_MAX > 1) ? $clog2(CHANNELS_MAX) : 1;
    localparam int CC_W  = ($clog2(CHANNELS_MAX + 1) > CFG_W + 1) ?
                           $clog2(CHANNELS_MAX + 1) : CFG_W + 1;
    localparam logic [CC_W-1:0] CC_LIMIT = CC_W'(CHANNELS_MAX);

    logic [CFG_W-1:0]        cfg_reg;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    pend_reg, pend_next;

    logic                    accept;
    logic                    restart;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [SUM_W-1:0] acc_base;
    logic [IDX_W-1:0]        idx_base;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic [CC_W-1:0]         cc_raw;
    logic [CC_W-1:0]         cc_eff;
    logic                    done;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tuser[0];
    assign smp      = s_tdata[SAMPLE_BITS-1:0];

    always_comb begin
        acc_base = restart ? '0 : acc_reg;
        idx_base = restart ? '0 : idx_reg;
        sum_wide = (SUM_W+1)'(acc_base) + (SUM_W+1)'(smp);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        cc_raw = CC_W'(cfg_reg);
        if (cc_raw == '0) begin
            cc_eff = CC_W'(1);
        end else if (cc_raw > CC_LIMIT) begin
            cc_eff = CC_LIMIT;
        end else begin
            cc_eff = cc_raw;
        end
        done = (CC_W'(idx_base) + CC_W'(1)) >= cc_eff;
    end

    always_comb begin
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        pend_next = pend_reg;
        if (accept) begin
            if (done) begin
                acc_next  = '0;
                idx_next  = '0;
                pend_next = 1'b0;
            end else begin
                acc_next  = sum_sat;
                idx_next  = idx_base + IDX_W'(1);
                pend_next = pend_reg || restart;
            end
        end
    end

    assign push                = accept && done;
    assign push_entry.sum      = sum_sat;
    assign push_entry.new_run  = restart || pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg  <= CFG_W'(1);
            acc_reg  <= '0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            acc_reg  <= acc_next;
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== src/csrs_queue.sv =====
// Two-entry queue of completed time samples between front and back end.
// Depends on csrs_pkg for the entry type.
module csrs_queue
    import csrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  csrs_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output csrs_entry_t head_entry
);

    csrs_entry_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/csrs_back.sv =====
// Back end: min/max, Welford mean and M2 update and the output register.
// Depends on csrs_pkg; serial divider and split multiplier run in place.
module csrs_back
    import csrs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  csrs_entry_t        head_entry,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata
);

    back_state_t               state_reg, state_next;
    logic signed [SUM_W-1:0]   x_reg;
    logic signed [SUM_W-1:0]   min_reg;
    logic signed [SUM_W-1:0]   max_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic [M2_W-1:0]           m2_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      neg_reg;
    logic [MAG_W-1:0]          div_a_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [MAG_W-1:0]          mag_d_reg;
    logic [MAG_W-1:0]          mag_e_reg;
    logic [2*HALF_W-1:0]       prod_reg;
    logic [1:0]                psel_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic signed [MEAN_W-1:0]  x_scaled;
    logic signed [MEAN_W-1:0]  head_scaled;
    logic signed [DEV_W-1:0]   d_val;
    logic [DEV_W-1:0]          d_mag;
    logic [CNT_W:0]            rem_sh;
    logic                      rem_ge;
    logic signed [DEV_W-1:0]   q_signed;
    logic signed [DEV_W-1:0]   mean_wide;
    logic signed [MEAN_W-1:0]  mean_new;
    logic signed [DEV_W-1:0]   e_val;
    logic [DEV_W-1:0]          e_mag;
    logic [2*HALF_W-1:0]       a_ext;
    logic [2*HALF_W-1:0]       b_ext;
    logic [HALF_W-1:0]         a_part;
    logic [HALF_W-1:0]         b_part;
    logic [PROD_W-1:0]         prod_shifted;
    logic [PROD_W-FRAC_BITS-1:0] scaled_prod;
    logic [M2_W-1:0]           m2_add;
    logic [M2_W:0]             m2_sum;
    logic                      first;
    logic                      out_free;

    assign x_scaled    = {x_reg, {FRAC_BITS{1'b0}}};
    assign head_scaled = {head_entry.sum, {FRAC_BITS{1'b0}}};
    assign first       = head_entry.new_run || (cnt_reg == '0);
    assign out_free    = !out_valid_reg || m_tready;
    assign pop         = (state_reg == S_IDLE) && head_valid;

    always_comb begin
        d_val = DEV_W'(head_scaled) - DEV_W'(mean_reg);
        d_mag = d_val[DEV_W-1] ? -d_val : d_val;

        rem_sh = {rem_reg, div_a_reg[MAG_W-1]};
        rem_ge = rem_sh >= {1'b0, cnt_reg};

        q_signed  = neg_reg ? -DEV_W'(div_a_reg) : DEV_W'(div_a_reg);
        mean_wide = DEV_W'(mean_reg) + q_signed;
        mean_new  = mean_wide[MEAN_W-1:0];
        e_val     = DEV_W'(x_scaled) - DEV_W'(mean_new);
        e_mag     = e_val[DEV_W-1] ? -e_val : e_val;

        a_ext  = (2*HALF_W)'(mag_d_reg);
        b_ext  = (2*HALF_W)'(mag_e_reg);
        a_part = step_reg[1] ? a_ext[2*HALF_W-1:HALF_W] : a_ext[HALF_W-1:0];
        b_part = step_reg[0] ? b_ext[2*HALF_W-1:HALF_W] : b_ext[HALF_W-1:0];

        case (psel_reg)
            2'd0:    prod_shifted = PROD_W'(prod_reg);
            2'd1:    prod_shifted = PROD_W'(prod_reg) << HALF_W;
            default: prod_shifted = PROD_W'(prod_reg) << (2 * HALF_W);
        endcase

        scaled_prod = acc_reg[PROD_W-1:FRAC_BITS];
        if (scaled_prod[PROD_W-FRAC_BITS-1:M2_W] != '0) begin
            m2_add = M2_MAX;
        end else begin
            m2_add = scaled_prod[M2_W-1:0];
        end
        m2_sum = {1'b0, m2_reg} + {1'b0, m2_add};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (head_valid) begin
                    state_next = first ? S_EMIT : S_DIV;
                end
            end
            S_DIV: begin
                if (step_reg == STEP_W'(MAG_W - 1)) begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN: state_next = S_MUL;
            S_MUL: begin
                if (step_reg == STEP_W'(4)) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                x_reg     <= head_entry.sum;
                neg_reg   <= d_val[DEV_W-1];
                div_a_reg <= d_mag[MAG_W-1:0];
                mag_d_reg <= d_mag[MAG_W-1:0];
                rem_reg   <= '0;
                step_reg  <= '0;
            end
            S_DIV: begin
                rem_reg   <= rem_ge ? rem_sh[CNT_W-1:0] - cnt_reg : rem_sh[CNT_W-1:0];
                div_a_reg <= {div_a_reg[MAG_W-2:0], rem_ge};
                step_reg  <= step_reg + STEP_W'(1);
            end
            S_MEAN: begin
                mag_e_reg <= e_mag[MAG_W-1:0];
                acc_reg   <= '0;
                step_reg  <= '0;
            end
            S_MUL: begin
                prod_reg <= a_part * b_part;
                psel_reg <= 2'(step_reg[1]) + 2'(step_reg[0]);
                if (step_reg != '0) begin
                    acc_reg <= acc_reg + prod_shifted;
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            min_reg       <= '0;
            max_reg       <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (head_valid) begin
                        if (first) begin
                            min_reg  <= head_entry.sum;
                            max_reg  <= head_entry.sum;
                            mean_reg <= head_scaled;
                            m2_reg   <= '0;
                            cnt_reg  <= CNT_W'(1);
                        end else begin
                            if (head_entry.sum < min_reg) begin
                                min_reg <= head_entry.sum;
                            end
                            if (head_entry.sum > max_reg) begin
                                max_reg <= head_entry.sum;
                            end
                            if (cnt_reg != CNT_MAX) begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                S_MEAN: mean_reg <= mean_new;
                S_ACC:  m2_reg <= m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free) begin
            out_data_reg <= OUT_W'({cnt_reg, m2_reg, mean_reg, max_reg, min_reg, x_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/channel_sum_running_stats_unit.sv =====
// Channel-summing running statistics: top level joining front, queue and back.
// Depends on csrs_pkg, csrs_front, csrs_queue and csrs_back.
//
// Use: write channel_count through cfg_wr_en/cfg_wr_data (reset value 1;
// zero acts as 1, values above CHANNELS_MAX act as CHANNELS_MAX). Feed one
// channel sample per item on the s_ channel, restart in s_tuser on the first
// channel of a new run. Each completed time sample gives one item on the m_
// channel: sum, run minimum and maximum, running mean and M2 (16 fraction
// bits) and sample count.
// Throughput: one channel item per cycle while the two-entry queue has room.
// The back end takes one sample at a time from the queue, popping it only
// while idle. The first sample of a run goes straight to the output stage;
// every other sample passes the bit-serial divide of the mean update, the
// four-part split multiply of the M2 term, the M2 update and the output.
// Reset: statistics, accumulator and queue clear; the next completed sample
// starts a run. A stalled m_tready holds the result; the queue then fills
// and s_tready drops until the receiver takes the item.
module channel_sum_running_stats_unit
    import csrs_pkg::*;
#(
    parameter int CHANNELS_MAX = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // channel_sample
    input  logic [0:0]         s_tuser,   // restart
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata    // sample_sum, run_min, run_max,
                                          // running_mean, deviation_sum,
                                          // sample_count, zero pad
);

    logic        push;
    csrs_entry_t push_entry;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    csrs_entry_t head_entry;

    csrs_front #(
        .CHANNELS_MAX (CHANNELS_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    csrs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    csrs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== src/csrs_checker.sv =====
// Port-level checks for channel_sum_running_stats_unit, bound to the top level.
// Depends on csrs_pkg for the result field offsets.
module csrs_checker
    import csrs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata
);

    logic signed [SUM_W-1:0]  o_sum;
    logic signed [SUM_W-1:0]  o_min;
    logic signed [SUM_W-1:0]  o_max;
    logic signed [MEAN_W-1:0] o_mean;
    logic [M2_W-1:0]          o_dev;
    logic [CNT_W-1:0]         o_cnt;

    assign o_sum  = m_tdata[OFS_SUM +: SUM_W];
    assign o_min  = m_tdata[OFS_MIN +: SUM_W];
    assign o_max  = m_tdata[OFS_MAX +: SUM_W];
    assign o_mean = m_tdata[OFS_MEAN +: MEAN_W];
    assign o_dev  = m_tdata[OFS_DEV +: M2_W];
    assign o_cnt  = m_tdata[OFS_CNT +: CNT_W];

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> o_cnt != '0)
        else $error("result with zero sample count");

    a_min_max_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (o_min <= o_sum) && (o_sum <= o_max))
        else $error("sum outside run minimum and maximum");

    a_first_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (o_cnt == CNT_W'(1)) |->
            (o_dev == '0) && (o_mean == {o_sum, {FRAC_BITS{1'b0}}}))
        else $error("first sample of run has wrong mean or M2");

endmodule

bind channel_sum_running_stats_unit csrs_checker u_csrs_checker (.*);
